// File: rtl/core/gpio_port_pin_control_assert.svh
// Assertion macros for the GPIO port pin control block.
// Each macro expands to a labeled concurrent assertion on i_clk / i_rst_n.
`ifndef GPIO_PORT_PIN_CONTROL_ASSERT_SVH
`define GPIO_PORT_PIN_CONTROL_ASSERT_SVH

// same-cycle implication
`define GPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gpp_pkg.sv
// Shared types, constants and the port table for the GPIO port pin control block.
// No dependencies.
`timescale 1ns / 1ps

package gpp_pkg;

    localparam int NUM_PORTS_DEF = 17;
    localparam int TABLE_LEN     = 17;
    localparam int WORD_W        = 32;

    typedef enum logic [1:0] {
        KIND_A = 2'd0,
        KIND_F = 2'd1,
        KIND_H = 2'd2
    } t_kind;

    typedef enum logic {
        OP_READ = 1'b0,
        OP_SET  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PIN  = 2'd1,
        ST_BAD_CODE = 2'd2
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] last;
    } t_port_info;

    typedef struct packed {
        t_op        op;
        logic [4:0] port_index;
        logic [4:0] pin_number;
        logic [2:0] function_code;
        logic       drive_level;
        logic       keep_level;
        logic [1:0] pull_code;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] fn;
        logic [WORD_W-1:0] fn_hi;
        logic [WORD_W-1:0] level;
        logic [WORD_W-1:0] pull;
    } t_port_words;

    typedef struct packed {
        t_status     status;
        logic [3:0]  read_function;
        logic        read_level;
        logic [1:0]  read_pull;
        logic        wr_en;
        t_port_words words;
    } t_res;

    function automatic t_port_info port_info(input logic [4:0] idx);
        t_port_info info;
        case (idx)
            5'd0:    info = '{KIND_A, 5'd8};
            5'd1:    info = '{KIND_A, 5'd7};
            5'd2:    info = '{KIND_A, 5'd8};
            5'd3:    info = '{KIND_A, 5'd5};
            5'd4:    info = '{KIND_A, 5'd5};
            5'd5:    info = '{KIND_F, 5'd16};
            5'd6:    info = '{KIND_A, 5'd7};
            5'd7:    info = '{KIND_H, 5'd10};
            5'd8:    info = '{KIND_F, 5'd16};
            5'd9:    info = '{KIND_F, 5'd12};
            5'd10:   info = '{KIND_H, 5'd16};
            5'd11:   info = '{KIND_H, 5'd15};
            5'd12:   info = '{KIND_A, 5'd6};
            5'd13:   info = '{KIND_F, 5'd16};
            5'd14:   info = '{KIND_F, 5'd16};
            5'd15:   info = '{KIND_F, 5'd15};
            5'd16:   info = '{KIND_F, 5'd9};
            default: info = '{KIND_A, 5'd0};
        endcase
        return info;
    endfunction

endpackage

// File: rtl/core/gpp_port_mem.sv
// Port word memory: one entry of four 32-bit words per port, registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses gpp_pkg.
`timescale 1ns / 1ps

module gpp_port_mem #(
    parameter int NUM_PORTS = gpp_pkg::NUM_PORTS_DEF,
    parameter int AW        = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output gpp_pkg::t_port_words  o_rd_words,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  gpp_pkg::t_port_words  i_wr_words
);

    gpp_pkg::t_port_words mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] r_valid;
    gpp_pkg::t_port_words r_rd_data;
    logic                 r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_words;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_words = r_rd_ok ? r_rd_data : '0;

endmodule

// File: rtl/core/gpp_pin_update.sv
// Pin field checks, read-modify of one port entry and readback extraction.
// Purely combinational. Uses gpp_pkg.
`timescale 1ns / 1ps

module gpp_pin_update #(
    parameter int NUM_PORTS = gpp_pkg::NUM_PORTS_DEF
) (
    input  gpp_pkg::t_req        i_req,
    input  gpp_pkg::t_port_words i_words,
    output gpp_pkg::t_res        o_res
);

    localparam int W = gpp_pkg::WORD_W;

    gpp_pkg::t_port_info  info;
    gpp_pkg::t_port_words w_new;
    logic         port_ok;
    logic         pin_ok;
    logic         is_f;
    logic         is_hi;
    logic         code_bad;
    logic         do_set;
    logic         wr;
    logic [4:0]   pin;
    logic [4:0]   fsh;
    logic [4:0]   psh;
    logic [W-1:0] fmask;
    logic [W-1:0] fw_old;
    logic [W-1:0] fw_new;
    logic [W-1:0] fsel;
    logic [W-1:0] ftmp;
    logic [W-1:0] ptmp;

    always_comb begin
        pin      = i_req.pin_number;
        info     = gpp_pkg::port_info(i_req.port_index);
        port_ok  = (32'(i_req.port_index) < NUM_PORTS) &&
                   (32'(i_req.port_index) < gpp_pkg::TABLE_LEN);
        is_f     = (info.kind == gpp_pkg::KIND_F);
        is_hi    = (info.kind == gpp_pkg::KIND_H) && (pin >= 5'd8);
        pin_ok   = port_ok && (pin <= info.last) && (pin <= 5'd15) &&
                   (is_f || is_hi || (pin <= 5'd7));
        code_bad = is_f && (i_req.function_code > 3'd3);
        do_set   = (i_req.op == gpp_pkg::OP_SET);
        wr       = pin_ok && do_set && !code_bad;

        fsh    = is_f ? {pin[3:0], 1'b0} : {pin[2:0], 2'b00};
        psh    = {pin[3:0], 1'b0};
        fmask  = is_f ? W'(3) : W'(15);
        fw_old = is_hi ? i_words.fn_hi : i_words.fn;
        fw_new = (fw_old & ~(fmask << fsh)) |
                 ((W'(i_req.function_code) & fmask) << fsh);

        w_new = i_words;
        if (wr) begin
            if (is_hi) begin
                w_new.fn_hi = fw_new;
            end else begin
                w_new.fn = fw_new;
            end
            if (!i_req.keep_level) begin
                w_new.level = (i_words.level & ~(W'(1) << pin)) |
                              (W'(i_req.drive_level) << pin);
            end
            w_new.pull = (i_words.pull & ~(W'(3) << psh)) |
                         (W'(i_req.pull_code) << psh);
        end

        fsel = is_hi ? w_new.fn_hi : w_new.fn;
        ftmp = (fsel >> fsh) & fmask;
        ptmp = w_new.pull >> psh;

        o_res.wr_en = wr;
        o_res.words = w_new;
        if (!pin_ok) begin
            o_res.status = gpp_pkg::ST_BAD_PIN;
        end else if (do_set && code_bad) begin
            o_res.status = gpp_pkg::ST_BAD_CODE;
        end else begin
            o_res.status = gpp_pkg::ST_OK;
        end
        if (o_res.status == gpp_pkg::ST_OK) begin
            o_res.read_function = ftmp[3:0];
            o_res.read_level    = w_new.level[pin];
            o_res.read_pull     = ptmp[1:0];
        end else begin
            o_res.read_function = '0;
            o_res.read_level    = 1'b0;
            o_res.read_pull     = '0;
        end
    end

endmodule

// File: rtl/core/gpio_port_pin_control.sv
// GPIO port pin control, top level. A request is handled in turn: the beat is
// accepted and the port entry is read from the port word memory, then the
// entry is checked, modified and written back while the result loads the
// output register. The memory read is registered. No request is taken while
// another is in flight, so a read never overlaps a pending write-back. A new
// request is taken once the previous write-back is done, even if that result
// still waits downstream; a second waiting result holds the write-back and
// with it the input. Reset clears per-port valid bits, so no clearing pass.
// Uses gpp_pkg, gpp_port_mem, gpp_pin_update, gpio_port_pin_control_assert.svh.
`timescale 1ns / 1ps

`include "gpio_port_pin_control_assert.svh"

module gpio_port_pin_control #(
    parameter int NUM_PORTS = gpp_pkg::NUM_PORTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [4:0] i_port_index,
    input  logic [4:0] i_pin_number,
    input  logic [2:0] i_function_code,
    input  logic       i_drive_level,
    input  logic       i_keep_level,
    input  logic [1:0] i_pull_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [3:0] o_read_function,
    output logic       o_read_level,
    output logic [1:0] o_read_pull
);

    localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    gpp_pkg::t_req        r_req;
    gpp_pkg::t_port_words rd_words;
    gpp_pkg::t_res        res;
    logic       r_busy;
    logic       n_busy;
    logic       r_out_valid;
    logic       n_out_valid;
    logic [1:0] r_status;
    logic [3:0] r_read_function;
    logic       r_read_level;
    logic [1:0] r_read_pull;
    logic       in_acc;
    logic       done;
    logic       mem_wr;

    assign o_in_stall = r_busy;
    assign in_acc     = i_in_valid && !r_busy;
    assign done       = r_busy && (!r_out_valid || !i_out_stall);
    assign mem_wr     = done && res.wr_en;

    gpp_port_mem #(
        .NUM_PORTS (NUM_PORTS),
        .AW        (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rd_addr  (i_port_index[AW-1:0]),
        .o_rd_words (rd_words),
        .i_wr_en    (mem_wr),
        .i_wr_addr  (r_req.port_index[AW-1:0]),
        .i_wr_words (res.words)
    );

    gpp_pin_update #(
        .NUM_PORTS (NUM_PORTS)
    ) u_upd (
        .i_req   (r_req),
        .i_words (rd_words),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= '{op:            gpp_pkg::t_op'(i_op),
                       port_index:    i_port_index,
                       pin_number:    i_pin_number,
                       function_code: i_function_code,
                       drive_level:   i_drive_level,
                       keep_level:    i_keep_level,
                       pull_code:     i_pull_code};
        end
        if (done) begin
            r_status        <= res.status;
            r_read_function <= res.read_function;
            r_read_level    <= res.read_level;
            r_read_pull     <= res.read_pull;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (done) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
        end
        if (in_acc) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_read_function = r_read_function;
    assign o_read_level    = r_read_level;
    assign o_read_pull     = r_read_pull;

    `GPP_ASSERT_NOW(a_err_zero_fields,
        o_out_valid && (o_status != gpp_pkg::ST_OK),
        (o_read_function == 4'd0) && !o_read_level && (o_read_pull == 2'd0),
        "readback fields nonzero on error status")
    `GPP_ASSERT_NOW(a_out_after_work, $rose(o_out_valid), $past(r_busy),
        "result appeared without a request in flight")
    `GPP_ASSERT_NOW(a_write_only_ok, mem_wr,
        (res.status == gpp_pkg::ST_OK) && (r_req.op == gpp_pkg::OP_SET),
        "port entry written on a failed or read request")
    `GPP_ASSERT_NEXT(a_accept_busy, in_acc, r_busy && o_in_stall,
        "accepted beat did not start memory access")

endmodule
